// ----- sv/i8080_pkg.sv -----
package i8080_pkg;

    localparam int unsigned AddrWidth = 16;
    localparam logic [AddrWidth-1:0] StartAddressReset = '0;

    typedef enum logic [1:0] {
        BUS_MREAD  = 2'd0,
        BUS_MWRITE = 2'd1,
        BUS_PIN    = 2'd2,
        BUS_POUT   = 2'd3
    } bus_kind_t;

    typedef enum logic [10:0] {
        PH_FETCH  = 11'b00000000001,
        PH_IMM1   = 11'b00000000010,
        PH_IMM2   = 11'b00000000100,
        PH_MREAD  = 11'b00000001000,
        PH_MWRITE = 11'b00000010000,
        PH_PIN    = 11'b00000100000,
        PH_POUT   = 11'b00001000000,
        PH_SR1    = 11'b00010000000,
        PH_SR2    = 11'b00100000000,
        PH_SW1    = 11'b01000000000,
        PH_SW2    = 11'b10000000000
    } phase_t;

    localparam logic [7:0] PswMask  = 8'hD5;
    localparam logic [7:0] PswFixed = 8'h02;
    localparam logic [7:0] PopMask  = 8'hD5;
    localparam logic [7:0] LogicKeep = 8'h2A;

    localparam logic [7:0] OP_LXI_H = 8'h21;
    localparam logic [7:0] OP_LXI_SP = 8'h31;
    localparam logic [7:0] OP_MVI_M = 8'h36;
    localparam logic [7:0] OP_HLT = 8'h76;
    localparam logic [7:0] OP_JMP = 8'hC3;
    localparam logic [7:0] OP_CALL = 8'hCD;
    localparam logic [7:0] OP_RET = 8'hC9;
    localparam logic [7:0] OP_ANI = 8'hE6;
    localparam logic [7:0] OP_XRI = 8'hEE;
    localparam logic [7:0] OP_ORI = 8'hF6;
    localparam logic [7:0] OP_IN = 8'hDB;
    localparam logic [7:0] OP_OUT = 8'hD3;
    localparam logic [7:0] OP_XCHG = 8'hEB;
    localparam logic [7:0] OP_POP_B = 8'hC1;
    localparam logic [7:0] OP_POP_D = 8'hD1;
    localparam logic [7:0] OP_POP_H = 8'hE1;
    localparam logic [7:0] OP_POP_PSW = 8'hF1;

    typedef struct packed {
        logic       request_valid;
        bus_kind_t  bus_kind;
        logic [15:0] bus_address;
        logic [7:0] write_data;
        logic       opcode_fetch;
        logic [4:0] instr_cycles;
        logic       fault;
    } result_t;

    function automatic logic is_call(input logic [7:0] op);
        return ((op & 8'hC7) == 8'hC4) || (op == OP_CALL);
    endfunction

    function automatic logic is_word_imm(input logic [7:0] op);
        return (op == OP_LXI_H) || (op == OP_LXI_SP) || (op == OP_JMP) || (op == OP_CALL)
            || ((op & 8'hC7) == 8'hC2) || ((op & 8'hC7) == 8'hC4);
    endfunction

    function automatic logic cond_true(input logic [7:0] op, input logic [7:0] f);
        logic bitv;
        unique case (op[5:4])
            2'd0: bitv = f[6];
            2'd1: bitv = f[0];
            2'd2: bitv = f[2];
            default: bitv = f[7];
        endcase
        return bitv == op[3];
    endfunction

endpackage

// ----- sv/i8080_stream_if.sv -----
interface i8080_stream_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

// ----- sv/i8080_exec.sv -----
module i8080_exec (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 step,
    input  logic                 action,
    input  logic [7:0]           read_data,
    input  logic [15:0]          start_address,
    output i8080_pkg::result_t   result
);
    logic [15:0] pc_reg, pc_next, sp_reg, sp_next;
    logic [15:0] bc_reg, bc_next, de_reg, de_next, hl_reg, hl_next, ow_reg, ow_next;
    logic [7:0]  a_reg, a_next, f_reg, f_next, op_reg, op_next;
    i8080_pkg::phase_t ph_reg, ph_next;
    logic halt_reg, halt_next, fault_reg, fault_next;

    logic [7:0] d, op;
    logic [2:0] dst, src;
    logic [7:0] srcv;
    logic [7:0] lop_v, lr, lf;
    logic [2:0] lkind;
    logic [15:0] w, pc1;

    always_comb
    begin
        unique case (src)
            3'd0: srcv = bc_reg[15:8];
            3'd1: srcv = bc_reg[7:0];
            3'd2: srcv = de_reg[15:8];
            3'd3: srcv = de_reg[7:0];
            3'd4: srcv = hl_reg[15:8];
            3'd5: srcv = hl_reg[7:0];
            3'd7: srcv = a_reg;
            default: srcv = 8'h00;
        endcase
    end

    // logic unit shared by register, memory and immediate forms
    always_comb
    begin
        unique case (lkind)
            3'd4: lr = a_reg & lop_v;
            3'd5: lr = a_reg ^ lop_v;
            default: lr = a_reg | lop_v;
        endcase
        lf = f_reg & i8080_pkg::LogicKeep;
        lf[7] = lr[7];
        lf[6] = (lr == 8'h00);
        lf[4] = (lkind == 3'd4) && (a_reg[3] | lop_v[3]);
        lf[2] = ~(^lr);
    end

    always_comb
    begin
        d = read_data;
        op = op_reg;
        pc_next = pc_reg; sp_next = sp_reg; bc_next = bc_reg; de_next = de_reg;
        hl_next = hl_reg; ow_next = ow_reg; a_next = a_reg; f_next = f_reg;
        op_next = op_reg; ph_next = ph_reg; halt_next = halt_reg; fault_next = fault_reg;
        result = '0;
        dst = op_reg[5:3];
        src = op_reg[2:0];
        lop_v = d;
        lkind = op_reg[5:3];
        pc1 = pc_reg + 16'd1;
        w = {d, ow_reg[7:0]};
        if (action)
        begin
            a_next = '0; f_next = '0; bc_next = '0; de_next = '0; hl_next = '0;
            sp_next = '0; ow_next = '0; op_next = '0; pc_next = start_address;
            halt_next = 1'b0; fault_next = 1'b0;
            ph_next = i8080_pkg::PH_FETCH;
            result.request_valid = 1'b1;
            result.bus_address = start_address;
            result.opcode_fetch = 1'b1;
        end
        else if (halt_reg)
        begin
            result.fault = fault_reg;
        end
        else
        begin
            // default result: a valid memory-read request; arms set address and fields or override
            result.request_valid = 1'b1;
            result.bus_kind = i8080_pkg::BUS_MREAD;
            unique case (ph_reg)
                i8080_pkg::PH_FETCH:
                begin
                    op = d;
                    dst = d[5:3];
                    src = d[2:0];
                    lkind = d[5:3];
                    lop_v = srcv;
                    op_next = d;
                    pc_next = pc1;
                    result.bus_address = pc1;
                    if ((d & 8'hC7) == 8'h06 || i8080_pkg::is_word_imm(d)
                        || d == i8080_pkg::OP_ANI || d == i8080_pkg::OP_XRI
                        || d == i8080_pkg::OP_ORI || d == i8080_pkg::OP_IN
                        || d == i8080_pkg::OP_OUT)
                        ph_next = i8080_pkg::PH_IMM1;
                    else if (d[7:6] == 2'b01 && d != i8080_pkg::OP_HLT)
                    begin
                        if (src == 3'd6)
                        begin
                            result.bus_address = hl_reg;
                            ph_next = i8080_pkg::PH_MREAD;
                        end
                        else if (dst == 3'd6)
                        begin
                            result.bus_kind = i8080_pkg::BUS_MWRITE;
                            result.bus_address = hl_reg;
                            result.write_data = srcv;
                            ph_next = i8080_pkg::PH_MWRITE;
                        end
                        else
                        begin
                            unique case (dst)
                                3'd0: bc_next[15:8] = srcv;
                                3'd1: bc_next[7:0] = srcv;
                                3'd2: de_next[15:8] = srcv;
                                3'd3: de_next[7:0] = srcv;
                                3'd4: hl_next[15:8] = srcv;
                                3'd5: hl_next[7:0] = srcv;
                                3'd7: a_next = srcv;
                                default: ;
                            endcase
                            result.opcode_fetch = 1'b1;
                            result.instr_cycles = 5'd5;
                            ph_next = i8080_pkg::PH_FETCH;
                        end
                    end
                    else if (d >= 8'hA0 && d <= 8'hB7)
                    begin
                        if (src == 3'd6)
                        begin
                            result.bus_address = hl_reg;
                            ph_next = i8080_pkg::PH_MREAD;
                        end
                        else
                        begin
                            a_next = lr; f_next = lf;
                            result.opcode_fetch = 1'b1;
                            result.instr_cycles = 5'd4;
                            ph_next = i8080_pkg::PH_FETCH;
                        end
                    end
                    else if ((d & 8'hC7) == 8'hC0 && !i8080_pkg::cond_true(d, f_reg))
                    begin
                        result.opcode_fetch = 1'b1;
                        result.instr_cycles = 5'd5;
                        ph_next = i8080_pkg::PH_FETCH;
                    end
                    else if ((d & 8'hC7) == 8'hC0 || (d & 8'hCF) == 8'hC1
                        || d == i8080_pkg::OP_RET)
                    begin
                        result.bus_address = sp_reg;
                        ph_next = i8080_pkg::PH_SR1;
                    end
                    else if ((d & 8'hCF) == 8'hC5)
                    begin
                        unique case (d[5:4])
                            2'd0: ow_next = bc_reg;
                            2'd1: ow_next = de_reg;
                            2'd2: ow_next = hl_reg;
                            default: ow_next = {a_reg,
                                (f_reg & i8080_pkg::PswMask) | i8080_pkg::PswFixed};
                        endcase
                        sp_next = sp_reg - 16'd2;
                        result.bus_kind = i8080_pkg::BUS_MWRITE;
                        result.bus_address = sp_reg - 16'd2;
                        result.write_data = ow_next[7:0];
                        ph_next = i8080_pkg::PH_SW1;
                    end
                    else if (d == i8080_pkg::OP_XCHG)
                    begin
                        de_next = hl_reg; hl_next = de_reg;
                        result.opcode_fetch = 1'b1;
                        result.instr_cycles = 5'd5;
                        ph_next = i8080_pkg::PH_FETCH;
                    end
                    else
                    begin
                        halt_next = 1'b1; fault_next = 1'b1;
                        ph_next = i8080_pkg::PH_FETCH;
                        result = '0;
                        result.fault = 1'b1;
                    end
                end
                i8080_pkg::PH_IMM1:
                begin
                    pc_next = pc1;
                    result.bus_address = pc1;
                    if (i8080_pkg::is_word_imm(op))
                    begin
                        ow_next = {8'h00, d};
                        ph_next = i8080_pkg::PH_IMM2;
                    end
                    else if (op == i8080_pkg::OP_MVI_M)
                    begin
                        result.bus_kind = i8080_pkg::BUS_MWRITE;
                        result.bus_address = hl_reg;
                        result.write_data = d;
                        ph_next = i8080_pkg::PH_MWRITE;
                    end
                    else if ((op & 8'hC7) == 8'h06)
                    begin
                        unique case (dst)
                            3'd0: bc_next[15:8] = d;
                            3'd1: bc_next[7:0] = d;
                            3'd2: de_next[15:8] = d;
                            3'd3: de_next[7:0] = d;
                            3'd4: hl_next[15:8] = d;
                            3'd5: hl_next[7:0] = d;
                            3'd7: a_next = d;
                            default: ;
                        endcase
                        result.opcode_fetch = 1'b1;
                        result.instr_cycles = 5'd7;
                        ph_next = i8080_pkg::PH_FETCH;
                    end
                    else if (op == i8080_pkg::OP_IN)
                    begin
                        result.bus_kind = i8080_pkg::BUS_PIN;
                        result.bus_address = {8'h00, d};
                        ph_next = i8080_pkg::PH_PIN;
                    end
                    else if (op == i8080_pkg::OP_OUT)
                    begin
                        result.bus_kind = i8080_pkg::BUS_POUT;
                        result.bus_address = {8'h00, d};
                        result.write_data = a_reg;
                        ph_next = i8080_pkg::PH_POUT;
                    end
                    else
                    begin
                        a_next = lr; f_next = lf;
                        result.opcode_fetch = 1'b1;
                        result.instr_cycles = 5'd7;
                        ph_next = i8080_pkg::PH_FETCH;
                    end
                end
                i8080_pkg::PH_IMM2:
                begin
                    pc_next = pc1;
                    ow_next = w;
                    result.opcode_fetch = 1'b1;
                    result.instr_cycles = 5'd10;
                    result.bus_address = pc1;
                    ph_next = i8080_pkg::PH_FETCH;
                    if (op == i8080_pkg::OP_LXI_H)
                        hl_next = w;
                    else if (op == i8080_pkg::OP_LXI_SP)
                        sp_next = w;
                    else if (i8080_pkg::is_call(op))
                    begin
                        if (op == i8080_pkg::OP_CALL || i8080_pkg::cond_true(op, f_reg))
                        begin
                            sp_next = sp_reg - 16'd2;
                            result.opcode_fetch = 1'b0;
                            result.instr_cycles = 5'd0;
                            result.bus_kind = i8080_pkg::BUS_MWRITE;
                            result.bus_address = sp_reg - 16'd2;
                            result.write_data = pc1[7:0];
                            ph_next = i8080_pkg::PH_SW1;
                        end
                        else
                            result.instr_cycles = 5'd11;
                    end
                    else if (op == i8080_pkg::OP_JMP || i8080_pkg::cond_true(op, f_reg))
                    begin
                        pc_next = w;
                        result.bus_address = w;
                    end
                end
                i8080_pkg::PH_MREAD:
                begin
                    if (!op[7])
                    begin
                        unique case (dst)
                            3'd0: bc_next[15:8] = d;
                            3'd1: bc_next[7:0] = d;
                            3'd2: de_next[15:8] = d;
                            3'd3: de_next[7:0] = d;
                            3'd4: hl_next[15:8] = d;
                            3'd5: hl_next[7:0] = d;
                            3'd7: a_next = d;
                            default: ;
                        endcase
                    end
                    else
                    begin
                        a_next = lr; f_next = lf;
                    end
                    result.opcode_fetch = 1'b1;
                    result.instr_cycles = 5'd7;
                    result.bus_address = pc_reg;
                    ph_next = i8080_pkg::PH_FETCH;
                end
                i8080_pkg::PH_MWRITE, i8080_pkg::PH_PIN, i8080_pkg::PH_POUT:
                begin
                    if (ph_reg == i8080_pkg::PH_PIN)
                        a_next = d;
                    result.opcode_fetch = 1'b1;
                    result.instr_cycles = (ph_reg == i8080_pkg::PH_MWRITE
                        && op != i8080_pkg::OP_MVI_M) ? 5'd7 : 5'd10;
                    result.bus_address = pc_reg;
                    ph_next = i8080_pkg::PH_FETCH;
                end
                i8080_pkg::PH_SR1:
                begin
                    ow_next = {8'h00, d};
                    result.bus_address = sp_reg + 16'd1;
                    ph_next = i8080_pkg::PH_SR2;
                end
                i8080_pkg::PH_SR2:
                begin
                    sp_next = sp_reg + 16'd2;
                    result.opcode_fetch = 1'b1;
                    result.instr_cycles = 5'd10;
                    result.bus_address = pc_reg;
                    ph_next = i8080_pkg::PH_FETCH;
                    if (op == i8080_pkg::OP_POP_B) bc_next = w;
                    else if (op == i8080_pkg::OP_POP_D) de_next = w;
                    else if (op == i8080_pkg::OP_POP_H) hl_next = w;
                    else if (op == i8080_pkg::OP_POP_PSW)
                    begin
                        a_next = d;
                        f_next = ow_reg[7:0] & i8080_pkg::PopMask;
                    end
                    else
                    begin
                        pc_next = w;
                        result.bus_address = w;
                        if (op != i8080_pkg::OP_RET)
                            result.instr_cycles = 5'd11;
                    end
                end
                i8080_pkg::PH_SW1:
                begin
                    result.bus_kind = i8080_pkg::BUS_MWRITE;
                    result.bus_address = sp_reg + 16'd1;
                    result.write_data = i8080_pkg::is_call(op) ? pc_reg[15:8] : ow_reg[15:8];
                    ph_next = i8080_pkg::PH_SW2;
                end
                default:
                begin
                    result.opcode_fetch = 1'b1;
                    result.instr_cycles = 5'd11;
                    result.bus_address = pc_reg;
                    if (i8080_pkg::is_call(op))
                    begin
                        pc_next = ow_reg;
                        result.instr_cycles = 5'd17;
                        result.bus_address = ow_reg;
                    end
                    ph_next = i8080_pkg::PH_FETCH;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg <= '0; sp_reg <= '0; bc_reg <= '0; de_reg <= '0; hl_reg <= '0;
            ow_reg <= '0; a_reg <= '0; f_reg <= '0; op_reg <= '0;
            ph_reg <= i8080_pkg::PH_FETCH; halt_reg <= 1'b1; fault_reg <= 1'b0;
        end
        else if (step)
        begin
            pc_reg <= pc_next; sp_reg <= sp_next; bc_reg <= bc_next; de_reg <= de_next;
            hl_reg <= hl_next; ow_reg <= ow_next; a_reg <= a_next; f_reg <= f_next;
            op_reg <= op_next; ph_reg <= ph_next; halt_reg <= halt_next;
            fault_reg <= fault_next;
        end
    end
endmodule

// ----- sv/i8080_subset_core.sv -----
// channel | direction | payload
// in      | sink      | action, read_data
// out     | source    | request_valid, bus_kind, bus_address, write_data,
//         |           | opcode_fetch, instr_cycles, fault
// one transaction per clock unless out stalls: a response is decoded against the
// architectural registers and the next request is registered in the same cycle
// the output register frees when taken or empty, so in.ready is out.ready or empty
// reset leaves the core halted until a restart transaction
module i8080_subset_core #(
    parameter logic [15:0] StartReset = i8080_pkg::StartAddressReset
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [15:0] cfg_wdata,
    i8080_stream_if.sink   in,
    i8080_stream_if.source out
);
    logic [15:0] start_reg;
    logic out_valid_reg;
    i8080_pkg::result_t res_reg, res_next;
    logic step;

    assign in.ready = !out_valid_reg || out.ready;
    assign step = in.valid && in.ready;

    i8080_exec u_exec (
        .clk          (clk),
        .rst_n        (rst_n),
        .step         (step),
        .action       (in.payload.action),
        .read_data    (in.payload.read_data),
        .start_address(start_reg),
        .result       (res_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_reg <= StartReset;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
                start_reg <= cfg_wdata;
            if (step)
                out_valid_reg <= 1'b1;
            else if (out.ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
            res_reg <= res_next;
    end

    assign out.valid = out_valid_reg;
    assign out.payload = res_reg;
endmodule

// ----- sv/i8080_checker.sv -----
module i8080_checker (
    input logic clk,
    input logic rst_n,
    input logic in_ready,
    input logic out_valid,
    input logic out_ready,
    input i8080_pkg::result_t res
);
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(res))
        else $error("result dropped under stall");
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |-> !in_ready)
        else $error("input taken while output blocked");
    a_idle: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !res.request_valid |-> res.bus_address == 16'h0 && !res.opcode_fetch)
        else $error("halted result not clear");
    a_cyc: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !res.opcode_fetch |-> res.instr_cycles == 5'd0)
        else $error("cycle count outside fetch");
endmodule

bind i8080_subset_core i8080_checker u_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ready (in.ready),
    .out_valid(out.valid),
    .out_ready(out.ready),
    .res      (out.payload)
);

// ----- sim/i8080_subset_core_test.sv -----
module i8080_subset_core_test;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic       action;
        logic [7:0] read_data;
    } bus_response_t;

    class core_scoreboard;
        i8080_pkg::result_t pending[$];
        int          mismatches;
        int          checked;
        int          restarts;
        int          faults;
        logic [15:0] start_addr;

        logic [15:0] pc, sp, bc, de, hl, opw;
        logic [7:0]  acc, flags, op;
        i8080_pkg::phase_t phase;
        logic        halted, flt;

        function new();
            mismatches = 0;
            checked = 0;
            restarts = 0;
            faults = 0;
            start_addr = '0;
            pc = '0; sp = '0; bc = '0; de = '0; hl = '0; opw = '0;
            acc = '0; flags = '0; op = '0;
            phase = i8080_pkg::PH_FETCH;
            halted = 1'b1;
            flt = 1'b0;
        endfunction

        function logic calls_sub(logic [7:0] o);
            return ((o & 8'hC7) == 8'hC4) || (o == i8080_pkg::OP_CALL);
        endfunction

        function logic takes_word(logic [7:0] o);
            return (o == i8080_pkg::OP_LXI_H) || (o == i8080_pkg::OP_LXI_SP)
                || (o == i8080_pkg::OP_JMP) || (o == i8080_pkg::OP_CALL)
                || ((o & 8'hC7) == 8'hC2) || ((o & 8'hC7) == 8'hC4);
        endfunction

        function logic takes_byte(logic [7:0] o);
            return ((o & 8'hC7) == 8'h06) || takes_word(o) || (o == i8080_pkg::OP_ANI)
                || (o == i8080_pkg::OP_XRI) || (o == i8080_pkg::OP_ORI)
                || (o == i8080_pkg::OP_IN) || (o == i8080_pkg::OP_OUT);
        endfunction

        function logic known(logic [7:0] o);
            return takes_byte(o) || (o >= 8'h40 && o <= 8'h7F && o != i8080_pkg::OP_HLT)
                || (o >= 8'hA0 && o <= 8'hB7) || ((o & 8'hC7) == 8'hC0)
                || ((o & 8'hCF) == 8'hC1) || (o == i8080_pkg::OP_RET)
                || ((o & 8'hCF) == 8'hC5) || (o == i8080_pkg::OP_XCHG);
        endfunction

        function logic cond_met(logic [7:0] o);
            logic b;
            case (o[5:4])
                2'd0: b = flags[6];
                2'd1: b = flags[0];
                2'd2: b = flags[2];
                default: b = flags[7];
            endcase
            return b == o[3];
        endfunction

        function logic [7:0] rget(logic [2:0] c);
            case (c)
                3'd0: return bc[15:8];
                3'd1: return bc[7:0];
                3'd2: return de[15:8];
                3'd3: return de[7:0];
                3'd4: return hl[15:8];
                3'd5: return hl[7:0];
                3'd7: return acc;
                default: return 8'h00;
            endcase
        endfunction

        function void rset(logic [2:0] c, logic [7:0] v);
            case (c)
                3'd0: bc[15:8] = v;
                3'd1: bc[7:0] = v;
                3'd2: de[15:8] = v;
                3'd3: de[7:0] = v;
                3'd4: hl[15:8] = v;
                3'd5: hl[7:0] = v;
                3'd7: acc = v;
                default: ;
            endcase
        endfunction

        // 4 and, 5 xor, otherwise or
        function void alu(logic [2:0] k, logic [7:0] v);
            logic [7:0] r, t;
            logic half;
            half = 1'b0;
            t = acc | v;
            if (k == 3'd4)
            begin
                r = acc & v;
                half = t[3];
            end
            else if (k == 3'd5)
                r = acc ^ v;
            else
                r = t;
            flags = flags & i8080_pkg::LogicKeep;
            flags[7] = r[7];
            flags[6] = (r == 8'h00);
            flags[4] = half;
            flags[2] = ~^r;
            acc = r;
        endfunction

        function i8080_pkg::result_t bus(i8080_pkg::bus_kind_t k, logic [15:0] a,
            logic [7:0] d, i8080_pkg::phase_t ph);
            i8080_pkg::result_t r;
            r = '0;
            r.request_valid = 1'b1;
            r.bus_kind = k;
            r.bus_address = a;
            r.write_data = d;
            phase = ph;
            return r;
        endfunction

        function i8080_pkg::result_t done(logic [4:0] cyc);
            i8080_pkg::result_t r;
            r = bus(i8080_pkg::BUS_MREAD, pc, 8'h00, i8080_pkg::PH_FETCH);
            r.opcode_fetch = 1'b1;
            r.instr_cycles = cyc;
            return r;
        endfunction

        function i8080_pkg::result_t idle_res();
            i8080_pkg::result_t r;
            r = '0;
            r.fault = flt;
            return r;
        endfunction

        function i8080_pkg::result_t push_low(logic [7:0] low);
            sp = sp - 16'd2;
            return bus(i8080_pkg::BUS_MWRITE, sp, low, i8080_pkg::PH_SW1);
        endfunction

        function i8080_pkg::result_t fetch(logic [7:0] d);
            logic [2:0] src, dst;
            logic [15:0] t;
            src = d[2:0];
            dst = d[5:3];
            op = d;
            pc = pc + 16'd1;
            if (takes_byte(d))
                return bus(i8080_pkg::BUS_MREAD, pc, 8'h00, i8080_pkg::PH_IMM1);
            if (d >= 8'h40 && d <= 8'h7F && d != i8080_pkg::OP_HLT)
            begin
                if (src == 3'd6)
                    return bus(i8080_pkg::BUS_MREAD, hl, 8'h00, i8080_pkg::PH_MREAD);
                if (dst == 3'd6)
                    return bus(i8080_pkg::BUS_MWRITE, hl, rget(src), i8080_pkg::PH_MWRITE);
                rset(dst, rget(src));
                return done(5'd5);
            end
            if (d >= 8'hA0 && d <= 8'hB7)
            begin
                if (src == 3'd6)
                    return bus(i8080_pkg::BUS_MREAD, hl, 8'h00, i8080_pkg::PH_MREAD);
                alu(dst, rget(src));
                return done(5'd4);
            end
            if ((d & 8'hC7) == 8'hC0)
            begin
                if (cond_met(d))
                    return bus(i8080_pkg::BUS_MREAD, sp, 8'h00, i8080_pkg::PH_SR1);
                return done(5'd5);
            end
            if (((d & 8'hCF) == 8'hC1) || d == i8080_pkg::OP_RET)
                return bus(i8080_pkg::BUS_MREAD, sp, 8'h00, i8080_pkg::PH_SR1);
            if ((d & 8'hCF) == 8'hC5)
            begin
                case (d[5:4])
                    2'd0: opw = bc;
                    2'd1: opw = de;
                    2'd2: opw = hl;
                    default: opw = {acc, (flags & i8080_pkg::PswMask) | i8080_pkg::PswFixed};
                endcase
                return push_low(opw[7:0]);
            end
            if (d == i8080_pkg::OP_XCHG)
            begin
                t = de;
                de = hl;
                hl = t;
                return done(5'd5);
            end
            halted = 1'b1;
            flt = 1'b1;
            faults++;
            phase = i8080_pkg::PH_FETCH;
            return idle_res();
        endfunction

        function void note(logic action, logic [7:0] d);
            i8080_pkg::result_t r;
            logic [15:0] w;
            if (action)
            begin
                acc = '0; flags = '0; bc = '0; de = '0; hl = '0; sp = '0; opw = '0; op = '0;
                pc = start_addr;
                halted = 1'b0;
                flt = 1'b0;
                restarts++;
                r = done(5'd0);
            end
            else if (halted)
                r = idle_res();
            else
            begin
                case (phase)
                    i8080_pkg::PH_IMM1:
                    begin
                        pc = pc + 16'd1;
                        if (takes_word(op))
                        begin
                            opw = {8'h00, d};
                            r = bus(i8080_pkg::BUS_MREAD, pc, 8'h00, i8080_pkg::PH_IMM2);
                        end
                        else if (op == i8080_pkg::OP_MVI_M)
                            r = bus(i8080_pkg::BUS_MWRITE, hl, d, i8080_pkg::PH_MWRITE);
                        else if ((op & 8'hC7) == 8'h06)
                        begin
                            rset(op[5:3], d);
                            r = done(5'd7);
                        end
                        else if (op == i8080_pkg::OP_IN)
                            r = bus(i8080_pkg::BUS_PIN, {8'h00, d}, 8'h00, i8080_pkg::PH_PIN);
                        else if (op == i8080_pkg::OP_OUT)
                            r = bus(i8080_pkg::BUS_POUT, {8'h00, d}, acc, i8080_pkg::PH_POUT);
                        else
                        begin
                            alu(op[5:3], d);
                            r = done(5'd7);
                        end
                    end
                    i8080_pkg::PH_IMM2:
                    begin
                        pc = pc + 16'd1;
                        opw[15:8] = d;
                        if (op == i8080_pkg::OP_LXI_H)
                        begin
                            hl = opw;
                            r = done(5'd10);
                        end
                        else if (op == i8080_pkg::OP_LXI_SP)
                        begin
                            sp = opw;
                            r = done(5'd10);
                        end
                        else if (calls_sub(op))
                        begin
                            if (op == i8080_pkg::OP_CALL || cond_met(op))
                                r = push_low(pc[7:0]);
                            else
                                r = done(5'd11);
                        end
                        else
                        begin
                            if (op == i8080_pkg::OP_JMP || cond_met(op))
                                pc = opw;
                            r = done(5'd10);
                        end
                    end
                    i8080_pkg::PH_MREAD:
                    begin
                        if (op < 8'h80)
                            rset(op[5:3], d);
                        else
                            alu(op[5:3], d);
                        r = done(5'd7);
                    end
                    i8080_pkg::PH_MWRITE: r = done(op == i8080_pkg::OP_MVI_M ? 5'd10 : 5'd7);
                    i8080_pkg::PH_PIN:
                    begin
                        acc = d;
                        r = done(5'd10);
                    end
                    i8080_pkg::PH_POUT: r = done(5'd10);
                    i8080_pkg::PH_SR1:
                    begin
                        opw = {8'h00, d};
                        r = bus(i8080_pkg::BUS_MREAD, sp + 16'd1, 8'h00, i8080_pkg::PH_SR2);
                    end
                    i8080_pkg::PH_SR2:
                    begin
                        w = {d, opw[7:0]};
                        sp = sp + 16'd2;
                        case (op)
                            i8080_pkg::OP_POP_B:
                            begin
                                bc = w;
                                r = done(5'd10);
                            end
                            i8080_pkg::OP_POP_D:
                            begin
                                de = w;
                                r = done(5'd10);
                            end
                            i8080_pkg::OP_POP_H:
                            begin
                                hl = w;
                                r = done(5'd10);
                            end
                            i8080_pkg::OP_POP_PSW:
                            begin
                                acc = w[15:8];
                                flags = w[7:0] & i8080_pkg::PopMask;
                                r = done(5'd10);
                            end
                            i8080_pkg::OP_RET:
                            begin
                                pc = w;
                                r = done(5'd10);
                            end
                            default:
                            begin
                                pc = w;
                                r = done(5'd11);
                            end
                        endcase
                    end
                    i8080_pkg::PH_SW1:
                    begin
                        w = calls_sub(op) ? pc : opw;
                        r = bus(i8080_pkg::BUS_MWRITE, sp + 16'd1, w[15:8], i8080_pkg::PH_SW2);
                    end
                    i8080_pkg::PH_SW2:
                    begin
                        if (calls_sub(op))
                        begin
                            pc = opw;
                            r = done(5'd17);
                        end
                        else
                            r = done(5'd11);
                    end
                    default: r = fetch(d);
                endcase
            end
            pending.push_back(r);
        endfunction

        function void check(i8080_pkg::result_t got);
            i8080_pkg::result_t exp;
            logic bad;
            if (pending.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected bus request %h with nothing pending", got);
                return;
            end
            exp = pending.pop_front();
            checked++;
            bad = (got.request_valid !== exp.request_valid) || (got.bus_kind !== exp.bus_kind)
                || (got.bus_address !== exp.bus_address) || (got.write_data !== exp.write_data)
                || (got.opcode_fetch !== exp.opcode_fetch)
                || (got.instr_cycles !== exp.instr_cycles) || (got.fault !== exp.fault);
            if (bad)
            begin
                mismatches++;
                if (mismatches <= 10)
                begin
                    $display("mismatch #%0d: exp v=%b k=%0d a=%h d=%h of=%b cyc=%0d f=%b",
                        checked, exp.request_valid, exp.bus_kind, exp.bus_address,
                        exp.write_data, exp.opcode_fetch, exp.instr_cycles, exp.fault);
                    $display("    got v=%b k=%0d a=%h d=%h of=%b cyc=%0d f=%b",
                        got.request_valid, got.bus_kind, got.bus_address, got.write_data,
                        got.opcode_fetch, got.instr_cycles, got.fault);
                end
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [15:0] cfg_wdata;
    int          src_idle;
    int          snk_idle;
    int          cycles;
    int          items;

    i8080_stream_if #(.payload_t(bus_response_t)) in_if();
    i8080_stream_if #(.payload_t(i8080_pkg::result_t)) out_if();

    core_scoreboard sb;

    i8080_subset_core dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_wdata(cfg_wdata),
        .in       (in_if),
        .out      (out_if)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > 600000)
        begin
            $display("timeout waiting for bus requests");
            $display("RESULT: ERROR");
            $finish;
        end
    end

    always @(negedge clk)
        if (rst_n)
            out_if.ready <= ($urandom_range(99) >= snk_idle);

    always @(posedge clk)
        if (rst_n && out_if.valid && out_if.ready)
            sb.check(out_if.payload);

    task automatic send(logic action, logic [7:0] d);
        while ($urandom_range(99) < src_idle)
        begin
            in_if.valid = 1'b0;
            @(negedge clk);
        end
        in_if.valid = 1'b1;
        in_if.payload = '{action: action, read_data: d};
        do
            @(posedge clk);
        while (!(in_if.valid && in_if.ready));
        sb.note(action, d);
        items++;
        @(negedge clk);
        in_if.valid = 1'b0;
    endtask

    task automatic write_start(logic [15:0] v);
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
        @(negedge clk);
        cfg_we = 1'b1;
        cfg_wdata = v;
        @(negedge clk);
        cfg_we = 1'b0;
        sb.start_addr = v;
    endtask

    function automatic logic [7:0] rand_byte();
        case ($urandom_range(9))
            0: return 8'h00;
            1: return 8'hFF;
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    task automatic random_item();
        logic [7:0] o;
        if (sb.halted)
            send($urandom_range(9) != 0, rand_byte());
        else if ($urandom_range(99) < 2)
            send(1'b1, rand_byte());
        else if (sb.phase == i8080_pkg::PH_FETCH)
        begin
            o = 8'($urandom_range(255));
            if ($urandom_range(99) >= 3)
                while (!sb.known(o))
                    o = 8'($urandom_range(255));
            send(1'b0, o);
        end
        else
            send(1'b0, rand_byte());
    endtask

    initial
    begin
        logic [8:0] directed[$];
        int lim[3];
        int rlim[3];
        logic [15:0] starts[3];
        // transaction list: completion while halted, restart, then a short program
        directed = '{
            9'h0FF, 9'h100, 9'h03E, 9'h0FF, 9'h0E6, 9'h00F, 9'h0EE, 9'h0FF, 9'h0F6, 9'h000,
            9'h0F5, 9'h000, 9'h000, 9'h0F1, 9'h0FF, 9'h0FF, 9'h0DB, 9'h080, 9'h055, 9'h0D3,
            9'h0FF, 9'h000, 9'h076, 9'h000, 9'h1AA
        };
        lim = '{25, 61, 0};
        rlim = '{61, 25, 0};
        sb = new();
        clk = 1'b0;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        in_if.valid = 1'b0;
        in_if.payload = '0;
        out_if.ready = 1'b0;
        cycles = 0;
        items = 0;
        src_idle = 0;
        snk_idle = 0;
        starts[0] = 16'hFFFF;
        starts[1] = 16'h0000;
        starts[2] = 16'($urandom_range(65535));
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        for (int p = 0; p < 3; p++)
        begin
            src_idle = lim[p];
            snk_idle = rlim[p];
            write_start(starts[p]);
            if (p == 0)
                foreach (directed[i])
                    send(directed[i][8], directed[i][7:0]);
            else
                send(1'b1, 8'h00);
            for (int i = 0; i < 440; i++)
                random_item();
        end
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        $display("sent %0d bus responses, checked %0d requests", items, sb.checked);
        $display("restarts %0d, faults %0d, mismatches %0d", sb.restarts, sb.faults,
            sb.mismatches);
        if (sb.mismatches == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end
endmodule
